// ----- sv/dmat_pkg.sv -----
// Shared types and constants for the dual moving-average trend block.
package dmat_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int TREND_W       = 4;
  localparam int ERR_W         = 12;
  localparam int WINDOW_DEF    = 8;
  localparam int STEER_OFFSET  = 150;
  localparam int SET_POINT_RST = 150;
  localparam int TREND_MAX     = 7;
  localparam int SIDES         = 2;

  // Side indexes into the per-side arrays.
  localparam int SIDE_LEFT  = 0;
  localparam int SIDE_RIGHT = 1;

  typedef logic [SAMPLE_W-1:0]       sample_t;
  typedef logic signed [TREND_W-1:0] trend_t;
  typedef logic signed [ERR_W-1:0]   err_t;

endpackage

// ----- sv/dmat_in_if.sv -----
// Input channel: one left/right sample pair per transaction.
interface dmat_in_if import dmat_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// Result channel: means, trend votes and steering error per transaction.
interface dmat_out_if import dmat_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_mean;
  sample_t right_mean;
  trend_t  left_trend;
  trend_t  right_trend;
  err_t    steer_error;

  modport source (output valid, output left_mean, output right_mean, output left_trend,
                  output right_trend, output steer_error, input ready);
  modport sink   (input valid, input left_mean, input right_mean, input left_trend,
                  input right_trend, input steer_error, output ready);
endinterface

// ----- sv/dual_moving_average_trend_top.sv -----
// Dual moving-average filter with trend vote and steering error (top level).
//
// Every input transaction carries one left and one right 10-bit sample. Each
// sample enters its side's window of the last WINDOW samples (the windows start
// as zeros after reset, and those zeros count like real samples). Each input
// transaction produces exactly one result transaction carrying, per side, the
// floor mean of the window and a trend vote (+1 for each time-adjacent pair
// where the newer sample is smaller, -1 otherwise, clamped to -7..7), plus
// steer_error = set_point + left_mean - right_mean - 150 in 12-bit two's
// complement. The block takes one transaction per clock; the result passes
// through stage A, stage B, stage C and the output register: the window shift
// line, a running sum and a running vote are updated at acceptance (only the
// pair leaving and the pair entering the window are compared), then the divide
// by WINDOW is a reciprocal multiply, a one-step remainder correction, and the
// final steering add. Each stage holds when the one after it is full, so a
// result waiting on out_if.ready stops new samples only once all four stages
// are full. set_point (reset 150) is written through cfg_we/cfg_wdata; the
// user writes it while the block is idle, which the block does not enforce.
module dual_moving_average_trend_top
  import dmat_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  sample_t           cfg_wdata,
  dmat_in_if.sink           in_if,
  dmat_out_if.source        out_if
);

  // Sum of a window fits SAMPLE_W + log2(WINDOW) bits.
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  // Vote spans -(WINDOW-1)..WINDOW-1.
  localparam int VOTE_W = $clog2(WINDOW) + 1;
  localparam int PROD_W = 2 * SUM_W;
  // Reciprocal for the divide: q_est = (sum * DIV_M) >> SUM_W, low by at most one.
  localparam longint unsigned DIV_M = (longint'(1) << SUM_W) / WINDOW;
  localparam int VOTE_RST = 1 - WINDOW;

  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic signed [VOTE_W-1:0] vote_t;

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or moves on.
  // ---------------------------------------------------------------------
  logic a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  logic a_en, b_en, c_en, out_en;
  logic accept;

  assign out_en = !out_valid_r || out_if.ready;
  assign c_en   = !c_valid_r   || out_en;
  assign b_en   = !b_valid_r   || c_en;
  assign a_en   = !a_valid_r   || b_en;

  assign in_if.ready = a_en;
  assign accept      = in_if.valid && a_en;

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  sample_t set_point_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_point_r <= sample_t'(SET_POINT_RST);
    end else if (cfg_we) begin
      set_point_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Window state: shift line (entry 0 newest), running sum, running vote.
  // ---------------------------------------------------------------------
  sample_t win_r  [SIDES][WINDOW];
  sum_t    sum_r  [SIDES];
  vote_t   vote_r [SIDES];
  sum_t    sum_nxt  [SIDES];
  vote_t   vote_nxt [SIDES];
  sample_t smp [SIDES];

  assign smp[SIDE_LEFT]  = in_if.left_sample;
  assign smp[SIDE_RIGHT] = in_if.right_sample;

  always_comb begin
    logic new_fall;
    logic old_fall;
    for (int s = 0; s < SIDES; s++) begin
      // Pair entering: previous newest vs. incoming sample.
      new_fall = smp[s] < win_r[s][0];
      // Pair leaving: oldest vs. second oldest.
      old_fall = win_r[s][WINDOW-2] < win_r[s][WINDOW-1];
      sum_nxt[s] = sum_r[s] + SUM_W'(smp[s]) - SUM_W'(win_r[s][WINDOW-1]);
      if (new_fall && !old_fall) begin
        vote_nxt[s] = vote_r[s] + VOTE_W'(2);
      end else if (!new_fall && old_fall) begin
        vote_nxt[s] = vote_r[s] - VOTE_W'(2);
      end else begin
        vote_nxt[s] = vote_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SIDES; s++) begin
        for (int k = 0; k < WINDOW; k++) begin
          win_r[s][k] <= '0;
        end
        sum_r[s]  <= '0;
        vote_r[s] <= VOTE_W'(VOTE_RST);
      end
    end else if (accept) begin
      for (int s = 0; s < SIDES; s++) begin
        win_r[s][0] <= smp[s];
        for (int k = 1; k < WINDOW; k++) begin
          win_r[s][k] <= win_r[s][k-1];
        end
        sum_r[s]  <= sum_nxt[s];
        vote_r[s] <= vote_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: snapshot of sum and vote for this transaction.
  // ---------------------------------------------------------------------
  sum_t  a_sum_r  [SIDES];
  vote_t a_vote_r [SIDES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_en) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int s = 0; s < SIDES; s++) begin
        a_sum_r[s]  <= sum_nxt[s];
        a_vote_r[s] <= vote_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: reciprocal multiply estimate of sum / WINDOW.
  // ---------------------------------------------------------------------
  sum_t    b_sum_r  [SIDES];
  sample_t b_q_r    [SIDES];
  vote_t   b_vote_r [SIDES];
  logic [PROD_W-1:0] prod [SIDES];

  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      prod[s] = PROD_W'(a_sum_r[s]) * PROD_W'(DIV_M);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      for (int s = 0; s < SIDES; s++) begin
        b_sum_r[s]  <= a_sum_r[s];
        b_q_r[s]    <= prod[s][SUM_W+SAMPLE_W-1:SUM_W];
        b_vote_r[s] <= a_vote_r[s];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: remainder correction of the mean, vote clamp to -7..7.
  // ---------------------------------------------------------------------
  sample_t c_mean_r  [SIDES];
  trend_t  c_trend_r [SIDES];
  sample_t mean_nxt  [SIDES];
  trend_t  trend_nxt [SIDES];

  always_comb begin
    sum_t             rem;
    logic signed [7:0] v8;
    for (int s = 0; s < SIDES; s++) begin
      rem = b_sum_r[s] - SUM_W'(SUM_W'(b_q_r[s]) * SUM_W'(WINDOW));
      if (rem >= SUM_W'(WINDOW)) begin
        mean_nxt[s] = b_q_r[s] + sample_t'(1);
      end else begin
        mean_nxt[s] = b_q_r[s];
      end
      v8 = {{(8-VOTE_W){b_vote_r[s][VOTE_W-1]}}, b_vote_r[s]};
      if (v8 > 8'(TREND_MAX)) begin
        trend_nxt[s] = trend_t'(TREND_MAX);
      end else if (v8 < -8'(TREND_MAX)) begin
        trend_nxt[s] = trend_t'(-TREND_MAX);
      end else begin
        trend_nxt[s] = v8[TREND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      for (int s = 0; s < SIDES; s++) begin
        c_mean_r[s]  <= mean_nxt[s];
        c_trend_r[s] <= trend_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: steering error and result transaction.
  // ---------------------------------------------------------------------
  sample_t out_lmean_r, out_rmean_r;
  trend_t  out_ltrend_r, out_rtrend_r;
  err_t    out_err_r;
  err_t    err_nxt;

  // Modulo-4096 arithmetic; the true range always fits 12 bits.
  assign err_nxt = ERR_W'(set_point_r) + ERR_W'(c_mean_r[SIDE_LEFT])
                 - ERR_W'(c_mean_r[SIDE_RIGHT]) - ERR_W'(STEER_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_lmean_r  <= c_mean_r[SIDE_LEFT];
      out_rmean_r  <= c_mean_r[SIDE_RIGHT];
      out_ltrend_r <= c_trend_r[SIDE_LEFT];
      out_rtrend_r <= c_trend_r[SIDE_RIGHT];
      out_err_r    <= err_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.left_mean   = out_lmean_r;
  assign out_if.right_mean  = out_rmean_r;
  assign out_if.left_trend  = out_ltrend_r;
  assign out_if.right_trend = out_rtrend_r;
  assign out_if.steer_error = out_err_r;

endmodule
